@@ design/bsc_pkg.sv @@
package bsc_pkg;

  localparam int unsigned OVERSAMPLING = 0;
  localparam int unsigned OSS_SH = OVERSAMPLING % 4;

  localparam int unsigned CFG_AW = 5;

  // Register byte addresses.
  localparam logic [CFG_AW-1:0] ADDR_AC1   = 5'd0;
  localparam logic [CFG_AW-1:0] ADDR_AC2   = 5'd4;
  localparam logic [CFG_AW-1:0] ADDR_AC3   = 5'd8;
  localparam logic [CFG_AW-1:0] ADDR_AC4   = 5'd12;
  localparam logic [CFG_AW-1:0] ADDR_AC5   = 5'd16;
  localparam logic [CFG_AW-1:0] ADDR_AC6   = 5'd20;
  localparam logic [CFG_AW-1:0] ADDR_B1_B2 = 5'd24;
  localparam logic [CFG_AW-1:0] ADDR_MC_MD = 5'd28;

  localparam logic [31:0] C_4000  = 32'd4000;
  localparam logic [31:0] C_32768 = 32'd32768;
  localparam logic [31:0] C_50000 = 32'd50000 >> OSS_SH;
  localparam logic [31:0] C_3038  = 32'd3038;
  localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
  localparam logic [31:0] C_3791  = 32'd3791;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
  } cal_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } op_req_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
    asr = 32'($signed(v) >>> n);
  endfunction

endpackage

@@ design/bsc_if.sv @@
interface bsc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [18:0] raw_reading;
  modport source(output valid, cmd, raw_reading, input ready);
  modport sink(input valid, cmd, raw_reading, output ready);
endinterface

interface bsc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] compensated_value;
  logic        is_pressure;
  logic        divide_error;
  modport source(output valid, compensated_value, is_pressure, divide_error, input ready);
  modport sink(input valid, compensated_value, is_pressure, divide_error, output ready);
endinterface

@@ design/bsc_mul.sv @@
// Shift-and-add multiplier, one bit of b per cycle, low 32 bits of a*b.
module bsc_mul
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  op_req_t     req,
  output logic        done,
  output logic [31:0] prod
);

  logic [31:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.start) begin
      a_nxt = req.a; b_nxt = req.b; acc_nxt = '0; cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1 || b_nxt == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ design/bsc_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
module bsc_div
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  op_req_t     req,
  output logic        done,
  output logic [31:0] quo
);

  logic [31:0] q_r, q_nxt, d_r, d_nxt;
  logic [32:0] rem_r, rem_nxt, trial;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.a; d_nxt = req.b; rem_nxt = '0; cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo = q_r;

endmodule

@@ design/bsc_seq.sv @@
// Sequencer: steps through the compensation formulas using the serial units.
module bsc_seq
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cal_t        cal,
  bsc_in_if.sink      in_ch,
  bsc_out_if.source   out_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_T1, S_T2, S_T3, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
    S_P9, S_P10, S_P11, S_P12, S_P13, S_WAIT, S_OUT
  } state_t;

  state_t      st_r, ret_r;
  logic        cmd_r, err_r, wdiv_r, ovalid_r;
  logic [18:0] raw_r;
  logic [31:0] tt_r, x1_r, x2_r, x3_r, sq_r, b6_r, b3_r, b4_r, b7_r, p_r, val_r;
  logic        neg_r;
  op_req_t     mreq, dreq;
  logic        mdone, ddone;
  logic [31:0] prod, quo, res;

  bsc_mul u_mul(.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .prod(prod));
  bsc_div u_div(.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quo(quo));

  logic [31:0] ac1, ac2, ac3, b1, b2, mc, md, den, numa, dena, b7x;
  assign ac1 = sx16(cal.ac1);
  assign ac2 = sx16(cal.ac2);
  assign ac3 = sx16(cal.ac3);
  assign b1  = sx16(cal.b1_b2[31:16]);
  assign b2  = sx16(cal.b1_b2[15:0]);
  assign mc  = sx16(cal.mc_md[31:16]);
  assign md  = sx16(cal.mc_md[15:0]);
  assign res = wdiv_r ? quo : prod;
  assign den = x1_r + md;
  assign numa = mc[31] ? 32'(-(mc << 11)) : (mc << 11);
  assign dena = den[31] ? 32'(-den) : den;
  assign b7x = b7_r;

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.compensated_value = val_r;
  assign out_ch.is_pressure = cmd_r;
  assign out_ch.divide_error = err_r;

  always_comb begin
    mreq = '0;
    dreq = '0;
    case (st_r)
      S_IDLE: if (in_ch.valid) begin
        mreq.start = !in_ch.cmd;
        mreq.a = 32'(in_ch.raw_reading) - 32'(cal.ac6);
        mreq.b = 32'(cal.ac5);
        if (in_ch.cmd) begin
          mreq.start = 1'b1;
          mreq.a = tt_r - C_4000;
          mreq.b = tt_r - C_4000;
        end
      end
      S_T1: if (den != '0) begin
        dreq.start = 1'b1; dreq.a = numa; dreq.b = dena;
      end
      S_P1: begin mreq.start = 1'b1; mreq.a = b2; mreq.b = sq_r; end
      S_P2: begin mreq.start = 1'b1; mreq.a = ac2; mreq.b = b6_r; end
      S_P3: begin mreq.start = 1'b1; mreq.a = ac3; mreq.b = b6_r; end
      S_P4: begin mreq.start = 1'b1; mreq.a = b1; mreq.b = sq_r; end
      S_P5: begin mreq.start = 1'b1; mreq.a = 32'(cal.ac4); mreq.b = x3_r + C_32768; end
      S_P6: begin mreq.start = 1'b1; mreq.a = 32'(raw_r) - b3_r; mreq.b = C_50000; end
      S_P7: if (b4_r != '0) begin
        dreq.start = 1'b1;
        dreq.a = b7x[31] ? b7x : (b7x << 1);
        dreq.b = b4_r;
      end
      S_P8: begin mreq.start = 1'b1; mreq.a = asr(p_r, 8); mreq.b = asr(p_r, 8); end
      S_P9: begin mreq.start = 1'b1; mreq.a = x1_r; mreq.b = C_3038; end
      S_P10: begin mreq.start = 1'b1; mreq.a = C_M7357; mreq.b = p_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ret_r <= S_IDLE; ovalid_r <= 1'b0; tt_r <= '0; wdiv_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          cmd_r <= in_ch.cmd; raw_r <= in_ch.raw_reading; err_r <= 1'b0;
          b6_r <= tt_r - C_4000; wdiv_r <= 1'b0;
          st_r <= S_WAIT; ret_r <= in_ch.cmd ? S_P1 : S_T1;
        end
        S_WAIT: if (wdiv_r ? ddone : mdone) begin
          st_r <= ret_r;
          case (ret_r)
            S_T1: x1_r <= asr(res, 15);
            S_T2: x2_r <= neg_r ? 32'(-res) : res;
            S_P1: sq_r <= asr(res, 12);
            S_P2: x1_r <= asr(res, 11);
            S_P3: x3_r <= x1_r + asr(res, 11);
            S_P4: x1_r <= asr(res, 13);
            S_P5: x3_r <= asr(x1_r + asr(res, 16) + 32'd2, 2);
            S_P6: b4_r <= res >> 15;
            S_P7: b7_r <= res;
            S_P8: p_r <= b7x[31] ? (res << 1) : res;
            S_P9: x1_r <= res;
            S_P10: x1_r <= asr(res, 16);
            S_P11: x2_r <= asr(res, 16);
            default: ;
          endcase
        end
        S_T1: if (den == '0) begin
          err_r <= 1'b1; val_r <= '0; ovalid_r <= 1'b1; st_r <= S_OUT;
        end else begin
          neg_r <= mc[31] ^ den[31]; wdiv_r <= 1'b1;
          st_r <= S_WAIT; ret_r <= S_T2;
        end
        S_T2: begin
          tt_r <= x1_r + x2_r;
          val_r <= asr(x1_r + x2_r + 32'd8, 4);
          ovalid_r <= 1'b1; st_r <= S_OUT;
        end
        S_P1: begin st_r <= S_WAIT; ret_r <= S_P2; end
        S_P2: begin st_r <= S_WAIT; ret_r <= S_P3; end
        S_P3: begin
          // b3 is ready once x3 is known; ac1*4 is a plain shift.
          st_r <= S_WAIT; ret_r <= S_P4;
        end
        S_P4: begin
          b3_r <= asr((((ac1 << 2) + x3_r) << OSS_SH) + 32'd2, 2);
          st_r <= S_WAIT; ret_r <= S_P5;
        end
        S_P5: begin st_r <= S_WAIT; ret_r <= S_P6; end
        S_P6: begin st_r <= S_WAIT; ret_r <= S_P7; end
        S_P7: if (b4_r == '0) begin
          err_r <= 1'b1; val_r <= '0; ovalid_r <= 1'b1; st_r <= S_OUT;
        end else begin
          wdiv_r <= 1'b1; st_r <= S_WAIT; ret_r <= S_P8;
        end
        S_P8: begin wdiv_r <= 1'b0; st_r <= S_WAIT; ret_r <= S_P9; end
        S_P9: begin st_r <= S_WAIT; ret_r <= S_P10; end
        S_P10: begin st_r <= S_WAIT; ret_r <= S_P11; end
        S_P11: st_r <= S_P12;
        S_P12: begin
          val_r <= p_r + asr(x1_r + x2_r + C_3791, 4);
          ovalid_r <= 1'b1; st_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          ovalid_r <= 1'b0; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/bsc_regs.sv @@
// APB register file holding the calibration coefficients.
module bsc_regs
  import bsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cal_t              cal
);

  cal_t cal_r;

  assign pready = 1'b1;
  assign cal = cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_AC1:   cal_r.ac1 <= pwdata[15:0];
        ADDR_AC2:   cal_r.ac2 <= pwdata[15:0];
        ADDR_AC3:   cal_r.ac3 <= pwdata[15:0];
        ADDR_AC4:   cal_r.ac4 <= pwdata[15:0];
        ADDR_AC5:   cal_r.ac5 <= pwdata[15:0];
        ADDR_AC6:   cal_r.ac6 <= pwdata[15:0];
        ADDR_B1_B2: cal_r.b1_b2 <= pwdata;
        ADDR_MC_MD: cal_r.mc_md <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_AC1:   prdata = 32'(cal_r.ac1);
      ADDR_AC2:   prdata = 32'(cal_r.ac2);
      ADDR_AC3:   prdata = 32'(cal_r.ac3);
      ADDR_AC4:   prdata = 32'(cal_r.ac4);
      ADDR_AC5:   prdata = 32'(cal_r.ac5);
      ADDR_AC6:   prdata = 32'(cal_r.ac6);
      ADDR_B1_B2: prdata = cal_r.b1_b2;
      ADDR_MC_MD: prdata = cal_r.mc_md;
      default:    prdata = '0;
    endcase
  end

endmodule

@@ design/barometric_sensor_compensation.sv @@
// Channel   Direction  Payload
// in_       sink       cmd, raw_reading
// out_      source     compensated_value, is_pressure, divide_error
// cfg_      APB        eight calibration registers at 4*i
//
// One transaction at a time. Temperature and pressure items are computed by a
// bit-serial multiplier, stopping early when the multiplier runs out of ones,
// and an unsigned serial restoring divider.
// rst_n is synchronous and clears the state, the b5 term and the calibration.
// A result waits in the output register until out_ready; no input is taken then.
module barometric_sensor_compensation
  import bsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bsc_in_if.sink            in_ch,
  bsc_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cal_t cal;

  bsc_regs u_regs(
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cal(cal)
  );

  bsc_seq u_seq(.clk(clk), .rst_n(rst_n), .cal(cal), .in_ch(in_ch), .out_ch(out_ch));

endmodule

@@ design/bsc_checker.sv @@
module bsc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_pressure,
  input logic out_divide_error,
  input logic [31:0] out_value
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_error) |-> (out_value == 32'd0))
    else $error("error result not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) &&
      $stable(out_is_pressure) && $stable(out_divide_error)))
    else $error("result dropped");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

endmodule

bind barometric_sensor_compensation bsc_checker u_chk(
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_is_pressure(out_ch.is_pressure), .out_divide_error(out_ch.divide_error),
  .out_value(out_ch.compensated_value)
);
